### rtl/length_tagged_message_fifo_core_defines.svh
// ------------------------------------------------------------------------
// length tagged message fifo core: assertion macros
// shared checking macros for the core's internal invariants
// ------------------------------------------------------------------------
`ifndef LENGTH_TAGGED_MESSAGE_FIFO_CORE_DEFINES_SVH
`define LENGTH_TAGGED_MESSAGE_FIFO_CORE_DEFINES_SVH

// condition must hold in the same cycle as the trigger
`define LTMF_ASSERT_HOLDS(label, trig, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (trig) |-> (cond)) else $error(msg);

// condition must hold in the cycle after the trigger
`define LTMF_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (trig) |=> (cond)) else $error(msg);

`endif

### rtl/ltmf_pkg.sv
// ------------------------------------------------------------------------
// ltmf_pkg
// shared types and constants of the length tagged message fifo core
// ------------------------------------------------------------------------
package ltmf_pkg;

    // default ring size in bytes (must be even)
    localparam int STORE_BYTES_DEF = 1024;
    // field widths fixed by the request format
    localparam int LEN_W  = 16;
    localparam int BYTE_W = 8;
    // width of pointer and space arithmetic before wrap
    localparam int SUM_W  = 18;
    // bytes taken by the little-endian length tag
    localparam int TAG_BYTES = 2;
    // free level at or below which the store reports full
    localparam int FULL_LEVEL = 2;

    // request operations
    typedef enum logic [2:0] {
        MODE_INS_BEGIN = 3'd0,
        MODE_INS_BYTE  = 3'd1,
        MODE_POP_BEGIN = 3'd2,
        MODE_POP_BYTE  = 3'd3,
        MODE_FLUSH     = 3'd4
    } t_mode;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_SPACE  = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_TOO_SMALL = 3'd3,
        ST_NO_XFER   = 3'd4
    } t_status;

    // write request into one byte bank
    typedef struct packed {
        logic              en;
        logic [BYTE_W-1:0] data;
    } t_byte_wr;

endpackage

### rtl/ltmf_bank.sv
// ------------------------------------------------------------------------
// ltmf_bank
// one byte bank of the ring store: one write and two registered reads,
// with a write-to-read bypass so a read sees the byte written that cycle
// ------------------------------------------------------------------------
module ltmf_bank #(
    parameter int DEPTH = ltmf_pkg::STORE_BYTES_DEF / 2,
    parameter int IW    = $clog2(ltmf_pkg::STORE_BYTES_DEF / 2)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ltmf_pkg::t_byte_wr              i_wr,
    input  logic [IW-1:0]                   i_wr_idx,
    input  logic [IW-1:0]                   i_rd_idx_a,
    input  logic [IW-1:0]                   i_rd_idx_b,
    output logic [ltmf_pkg::BYTE_W-1:0]     o_q_a,
    output logic [ltmf_pkg::BYTE_W-1:0]     o_q_b
);

    logic [ltmf_pkg::BYTE_W-1:0] r_mem [DEPTH];
    logic [ltmf_pkg::BYTE_W-1:0] r_q_a;
    logic [ltmf_pkg::BYTE_W-1:0] r_q_b;
    logic [ltmf_pkg::BYTE_W-1:0] r_wd;
    logic                        r_hit_a;
    logic                        r_hit_b;

    // storage array, write and registered reads
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr_idx] <= i_wr.data;
        end
        r_q_a <= r_mem[i_rd_idx_a];
        r_q_b <= r_mem[i_rd_idx_b];
        r_wd  <= i_wr.data;
    end

    // bypass flags for reads that collide with the write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_a <= 1'b0;
            r_hit_b <= 1'b0;
        end else begin
            r_hit_a <= i_wr.en && (i_wr_idx == i_rd_idx_a);
            r_hit_b <= i_wr.en && (i_wr_idx == i_rd_idx_b);
        end
    end

    assign o_q_a = r_hit_a ? r_wd : r_q_a;
    assign o_q_b = r_hit_b ? r_wd : r_q_b;

endmodule

### rtl/ltmf_ctrl.sv
// ------------------------------------------------------------------------
// ltmf_ctrl
// pointer and count state of the ring, single-pass request decode and
// the result register; drives the bank writes and the prefetch reads
// ------------------------------------------------------------------------
`include "length_tagged_message_fifo_core_defines.svh"

module ltmf_ctrl #(
    parameter int STORE_BYTES = ltmf_pkg::STORE_BYTES_DEF,
    localparam int PW = $clog2(STORE_BYTES),
    localparam int IW = PW - 1,
    localparam int UW = $clog2(STORE_BYTES + 1),
    localparam int CW = $clog2(STORE_BYTES / 2 + 1)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_proc,
    input  logic [2:0]                          i_mode,
    input  logic [ltmf_pkg::LEN_W-1:0]          i_msg_length,
    input  logic [ltmf_pkg::LEN_W-1:0]          i_capacity,
    input  logic [ltmf_pkg::BYTE_W-1:0]         i_data_byte,
    input  logic [1:0][ltmf_pkg::BYTE_W-1:0]    i_tag_q,
    input  logic [1:0][ltmf_pkg::BYTE_W-1:0]    i_dat_q,
    output ltmf_pkg::t_byte_wr [1:0]            o_wr,
    output logic [1:0][IW-1:0]                  o_wr_idx,
    output logic [1:0][IW-1:0]                  o_tag_idx,
    output logic [IW-1:0]                       o_dat_idx,
    output logic [2:0]                          o_status,
    output logic [ltmf_pkg::BYTE_W-1:0]         o_out_byte,
    output logic [ltmf_pkg::LEN_W-1:0]          o_popped_length,
    output logic                                o_last,
    output logic [UW-1:0]                       o_free_bytes,
    output logic [CW-1:0]                       o_msg_count,
    output logic                                o_empty_res,
    output logic                                o_full_res
);

    localparam int SW = ltmf_pkg::SUM_W;

    // ring state
    logic [PW-1:0]              r_wp, n_wp;
    logic [PW-1:0]              r_rp, n_rp;
    logic [PW-1:0]              r_tp, n_tp;   // next tag slot: read pointer plus pop rest
    logic [UW-1:0]              r_used, n_used;
    logic [CW-1:0]              r_cnt, n_cnt;
    logic [ltmf_pkg::LEN_W-1:0] r_wrem, n_wrem;
    logic [ltmf_pkg::LEN_W-1:0] r_rrem, n_rrem;

    // result register
    ltmf_pkg::t_status          r_status, n_status;
    logic [ltmf_pkg::BYTE_W-1:0] r_out_byte, n_out_byte;
    logic [ltmf_pkg::LEN_W-1:0] r_plen, n_plen;
    logic                       r_last, n_last;
    logic [UW-1:0]              r_free, n_free;
    logic [CW-1:0]              r_msg_cnt;
    logic                       r_empty;
    logic                       r_full;

    // decode helpers
    logic [PW-1:0]              wp_c;
    logic [PW-1:0]              wp_c1;
    logic [CW-1:0]              cnt_c;
    logic [SW-1:0]              free_now;
    logic [SW-1:0]              need;
    logic [UW-1:0]              used_d;
    logic [ltmf_pkg::LEN_W-1:0] tag;
    logic [ltmf_pkg::BYTE_W-1:0] dat;
    logic [PW-1:0]              tp1;

    // ring add with a single wrap
    function automatic logic [PW-1:0] ptr_add(input logic [PW-1:0] p,
                                              input logic [SW-1:0] k);
        logic [SW-1:0] s;
        s = SW'(p) + k;
        if (s >= SW'(STORE_BYTES)) begin
            s = s - SW'(STORE_BYTES);
        end
        return s[PW-1:0];
    endfunction

    // values shared by the request arms
    always_comb begin
        wp_c     = ptr_add(r_wp, SW'(r_wrem));
        wp_c1    = ptr_add(wp_c, SW'(1));
        cnt_c    = (r_wrem != '0) ? (r_cnt + CW'(1)) : r_cnt;
        free_now = SW'(STORE_BYTES) - SW'(r_used);
        need     = SW'(i_msg_length) + SW'(ltmf_pkg::TAG_BYTES);
        used_d   = r_used - UW'(r_rrem);
        tag      = {i_tag_q[~r_tp[0]], i_tag_q[r_tp[0]]};
        dat      = i_dat_q[r_rp[0]];
    end

    // next state, bank writes and result fields
    always_comb begin
        n_wp       = r_wp;
        n_rp       = r_rp;
        n_tp       = r_tp;
        n_used     = r_used;
        n_cnt      = r_cnt;
        n_wrem     = r_wrem;
        n_rrem     = r_rrem;
        n_status   = ltmf_pkg::ST_OK;
        n_out_byte = '0;
        n_plen     = '0;
        n_last     = 1'b0;
        o_wr       = '0;
        o_wr_idx   = '0;
        if (i_proc) begin
            unique case (i_mode)
                ltmf_pkg::MODE_INS_BEGIN: begin
                    // close any open insert as it stands, then reserve
                    n_wp   = wp_c;
                    n_cnt  = cnt_c;
                    n_wrem = '0;
                    if (free_now < need) begin
                        n_status = ltmf_pkg::ST_NO_SPACE;
                    end else begin
                        o_wr[wp_c[0]].en       = 1'b1;
                        o_wr[wp_c[0]].data     = i_msg_length[7:0];
                        o_wr_idx[wp_c[0]]      = wp_c[PW-1:1];
                        o_wr[~wp_c[0]].en      = 1'b1;
                        o_wr[~wp_c[0]].data    = i_msg_length[15:8];
                        o_wr_idx[~wp_c[0]]     = wp_c1[PW-1:1];
                        n_wp   = ptr_add(wp_c, SW'(ltmf_pkg::TAG_BYTES));
                        n_used = r_used + UW'(need);
                        n_wrem = i_msg_length;
                        if (i_msg_length == '0) begin
                            n_cnt = cnt_c + CW'(1);
                        end
                    end
                end
                ltmf_pkg::MODE_INS_BYTE: begin
                    if (r_wrem == '0) begin
                        n_status = ltmf_pkg::ST_NO_XFER;
                    end else begin
                        o_wr[r_wp[0]].en   = 1'b1;
                        o_wr[r_wp[0]].data = i_data_byte;
                        o_wr_idx[r_wp[0]]  = r_wp[PW-1:1];
                        n_wp   = ptr_add(r_wp, SW'(1));
                        n_wrem = r_wrem - ltmf_pkg::LEN_W'(1);
                        if (r_wrem == ltmf_pkg::LEN_W'(1)) begin
                            n_cnt = r_cnt + CW'(1);
                        end
                    end
                end
                ltmf_pkg::MODE_POP_BEGIN: begin
                    // drop the rest of an open pop: read pointer moves to the tag slot
                    n_rp   = r_tp;
                    n_used = used_d;
                    n_rrem = '0;
                    if (r_cnt == '0) begin
                        n_status = ltmf_pkg::ST_EMPTY;
                    end else if (i_capacity >= tag) begin
                        n_rp   = ptr_add(r_tp, SW'(ltmf_pkg::TAG_BYTES));
                        n_tp   = ptr_add(r_tp, SW'(tag) + SW'(ltmf_pkg::TAG_BYTES));
                        n_used = used_d - UW'(ltmf_pkg::TAG_BYTES);
                        n_cnt  = r_cnt - CW'(1);
                        n_rrem = tag;
                        n_plen = tag;
                    end else begin
                        n_status = ltmf_pkg::ST_TOO_SMALL;
                    end
                end
                ltmf_pkg::MODE_POP_BYTE: begin
                    if (r_rrem == '0) begin
                        n_status = ltmf_pkg::ST_NO_XFER;
                    end else begin
                        n_out_byte = dat;
                        n_rp       = ptr_add(r_rp, SW'(1));
                        n_used     = r_used - UW'(1);
                        n_rrem     = r_rrem - ltmf_pkg::LEN_W'(1);
                        n_last     = (r_rrem == ltmf_pkg::LEN_W'(1));
                    end
                end
                ltmf_pkg::MODE_FLUSH: begin
                    n_wp   = '0;
                    n_rp   = '0;
                    n_tp   = '0;
                    n_used = '0;
                    n_cnt  = '0;
                    n_wrem = '0;
                    n_rrem = '0;
                end
                default: begin
                    n_status = ltmf_pkg::ST_NO_XFER;
                end
            endcase
        end
        n_free = UW'(STORE_BYTES) - n_used;
    end

    // prefetch reads: tag bytes at the next tag slot, data byte at the read pointer
    always_comb begin
        tp1                 = ptr_add(n_tp, SW'(1));
        o_tag_idx[n_tp[0]]  = n_tp[PW-1:1];
        o_tag_idx[~n_tp[0]] = tp1[PW-1:1];
        o_dat_idx           = n_rp[PW-1:1];
    end

    // ring state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_tp   <= '0;
            r_used <= '0;
            r_cnt  <= '0;
            r_wrem <= '0;
            r_rrem <= '0;
        end else begin
            r_wp   <= n_wp;
            r_rp   <= n_rp;
            r_tp   <= n_tp;
            r_used <= n_used;
            r_cnt  <= n_cnt;
            r_wrem <= n_wrem;
            r_rrem <= n_rrem;
        end
    end

    // result register, loaded once per request
    always_ff @(posedge i_clk) begin
        if (i_proc) begin
            r_status   <= n_status;
            r_out_byte <= n_out_byte;
            r_plen     <= n_plen;
            r_last     <= n_last;
            r_free     <= n_free;
            r_msg_cnt  <= n_cnt;
            r_empty    <= (n_used == '0);
            r_full     <= (n_free <= UW'(ltmf_pkg::FULL_LEVEL));
        end
    end

    assign o_status        = r_status;
    assign o_out_byte      = r_out_byte;
    assign o_popped_length = r_plen;
    assign o_last          = r_last;
    assign o_free_bytes    = r_free;
    assign o_msg_count     = r_msg_cnt;
    assign o_empty_res     = r_empty;
    assign o_full_res      = r_full;

    // every held message owns at least its tag
    `LTMF_ASSERT_HOLDS(a_msgs_fit_used, 1'b1, (SW'(r_cnt) << 1) <= SW'(r_used), "message count exceeds used bytes")
    // the rest of an open pop is still counted as used
    `LTMF_ASSERT_HOLDS(a_pop_rest_used, r_rrem != '0, SW'(r_rrem) <= SW'(r_used), "open pop larger than used bytes")
    // an empty ring has all pointers together and no open transfer
    `LTMF_ASSERT_HOLDS(a_empty_aligned, r_used == '0, (r_wp == r_tp) && (r_wp == r_rp) && (r_wrem == '0), "empty ring with misaligned pointers")
    // a pop begin never adds a message
    `LTMF_ASSERT_NEXT(a_pop_no_grow, i_proc && (i_mode == ltmf_pkg::MODE_POP_BEGIN), r_cnt <= $past(r_cnt), "pop begin raised message count")

endmodule

### rtl/length_tagged_message_fifo_core.sv
// ------------------------------------------------------------------------
// length_tagged_message_fifo_core
// byte ring fifo of variable-length messages behind 2-byte length tags
// ------------------------------------------------------------------------
// Takes one request per clock and returns exactly one result per request,
// passed through the input register and then the result register; a
// stalled result holds the request behind it in the input register and
// stalls the request channel until the result is taken. The rate is set by
// the ring store, split into an even and an odd byte bank so that a tag's
// two bytes are written together, and the head tag read together; the head
// tag and head data byte are prefetched into the banks' read registers as
// the pointers move. STORE_BYTES must be even. No clearing pass runs after
// reset: store bytes are undefined until written and are never read first.
// ------------------------------------------------------------------------
module length_tagged_message_fifo_core #(
    parameter int STORE_BYTES = ltmf_pkg::STORE_BYTES_DEF,
    localparam int UW = $clog2(STORE_BYTES + 1),
    localparam int CW = $clog2(STORE_BYTES / 2 + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [2:0]                    i_mode,
    input  logic [ltmf_pkg::LEN_W-1:0]    i_msg_length,
    input  logic [ltmf_pkg::LEN_W-1:0]    i_capacity,
    input  logic [ltmf_pkg::BYTE_W-1:0]   i_data_byte,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [2:0]                    o_status,
    output logic [ltmf_pkg::BYTE_W-1:0]   o_out_byte,
    output logic [ltmf_pkg::LEN_W-1:0]    o_popped_length,
    output logic                          o_last,
    output logic [UW-1:0]                 o_free_bytes,
    output logic [CW-1:0]                 o_msg_count,
    output logic                          o_empty_res,
    output logic                          o_full_res
);

    localparam int PW = $clog2(STORE_BYTES);
    localparam int IW = PW - 1;

    // input register
    logic                          r_in_valid;
    logic [2:0]                    r_mode;
    logic [ltmf_pkg::LEN_W-1:0]    r_msg_length;
    logic [ltmf_pkg::LEN_W-1:0]    r_capacity;
    logic [ltmf_pkg::BYTE_W-1:0]   r_data_byte;
    logic                          r_out_valid;

    logic                          adv;
    logic                          proc;
    logic                          in_acc;

    ltmf_pkg::t_byte_wr [1:0]          wr;
    logic [1:0][IW-1:0]                wr_idx;
    logic [1:0][IW-1:0]                tag_idx;
    logic [IW-1:0]                     dat_idx;
    logic [1:0][ltmf_pkg::BYTE_W-1:0]  tag_q;
    logic [1:0][ltmf_pkg::BYTE_W-1:0]  dat_q;

    // handshake: the result slot frees when empty or taken
    assign adv        = !r_out_valid || !i_out_stall;
    assign proc       = r_in_valid && adv;
    assign o_in_stall = r_in_valid && !adv;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_in_valid <= 1'b1;
            end else if (proc) begin
                r_in_valid <= 1'b0;
            end
            if (proc) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request payload register
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mode       <= i_mode;
            r_msg_length <= i_msg_length;
            r_capacity   <= i_capacity;
            r_data_byte  <= i_data_byte;
        end
    end

    // pointer state, decode and result register
    ltmf_ctrl #(
        .STORE_BYTES (STORE_BYTES)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_proc          (proc),
        .i_mode          (r_mode),
        .i_msg_length    (r_msg_length),
        .i_capacity      (r_capacity),
        .i_data_byte     (r_data_byte),
        .i_tag_q         (tag_q),
        .i_dat_q         (dat_q),
        .o_wr            (wr),
        .o_wr_idx        (wr_idx),
        .o_tag_idx       (tag_idx),
        .o_dat_idx       (dat_idx),
        .o_status        (o_status),
        .o_out_byte      (o_out_byte),
        .o_popped_length (o_popped_length),
        .o_last          (o_last),
        .o_free_bytes    (o_free_bytes),
        .o_msg_count     (o_msg_count),
        .o_empty_res     (o_empty_res),
        .o_full_res      (o_full_res)
    );

    // even and odd byte banks of the ring
    for (genvar b = 0; b < 2; b++) begin : g_bank
        ltmf_bank #(
            .DEPTH (STORE_BYTES / 2),
            .IW    (IW)
        ) u_bank (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_wr       (wr[b]),
            .i_wr_idx   (wr_idx[b]),
            .i_rd_idx_a (tag_idx[b]),
            .i_rd_idx_b (dat_idx),
            .o_q_a      (tag_q[b]),
            .o_q_b      (dat_q[b])
        );
    end

endmodule
